@@ rtl/egcd_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// egcd_pkg
// Shared types for the extended gcd unit: micro-op and jump-condition codes,
// the control word layout, step addresses and the sequencer/datapath structs.
// ----------------------------------------------------------------------------
package egcd_pkg;

	typedef logic [2:0] pc_t;

	typedef enum logic [2:0] {
		OP_NOP,
		OP_ACCEPT,
		OP_DIV_INIT,
		OP_DIV_STEP,
		OP_UPDATE,
		OP_EMIT
	} op_t;

	// jump to target when the condition holds, otherwise fall through
	typedef enum logic [2:0] {
		C_NEVER,
		C_ALWAYS,
		C_NO_INPUT,
		C_RCUR_ZERO,
		C_DIV_BUSY,
		C_OUT_FULL
	} cond_t;

	typedef struct packed {
		op_t   op;
		cond_t cond;
		pc_t   target;
	} ucode_t;

	localparam pc_t PC_IDLE   = 3'd0;
	localparam pc_t PC_TEST   = 3'd1;
	localparam pc_t PC_SETUP  = 3'd2;
	localparam pc_t PC_DIV    = 3'd3;
	localparam pc_t PC_UPDATE = 3'd4;
	localparam pc_t PC_EMIT   = 3'd5;
	localparam pc_t PC_RETURN = 3'd6;

	typedef struct packed {
		logic in_ready;
		logic load;
		logic div_init;
		logic div_step;
		logic update;
		logic emit;
	} seq_ctrl_t;

	typedef struct packed {
		logic rcur_zero;
		logic div_last;
	} dp_status_t;

endpackage
`default_nettype wire

@@ rtl/egcd_ucode_rom.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// egcd_ucode_rom
// Control store: one control word per step of the euclid program.
// ----------------------------------------------------------------------------
module egcd_ucode_rom (
	input  wire egcd_pkg::pc_t addr,
	output egcd_pkg::ucode_t   word
);

	always_comb begin
		unique case (addr)
			egcd_pkg::PC_IDLE:
				word = '{egcd_pkg::OP_ACCEPT, egcd_pkg::C_NO_INPUT, egcd_pkg::PC_IDLE};
			egcd_pkg::PC_TEST:
				word = '{egcd_pkg::OP_NOP, egcd_pkg::C_RCUR_ZERO, egcd_pkg::PC_EMIT};
			egcd_pkg::PC_SETUP:
				word = '{egcd_pkg::OP_DIV_INIT, egcd_pkg::C_NEVER, egcd_pkg::PC_IDLE};
			egcd_pkg::PC_DIV:
				word = '{egcd_pkg::OP_DIV_STEP, egcd_pkg::C_DIV_BUSY, egcd_pkg::PC_DIV};
			egcd_pkg::PC_UPDATE:
				word = '{egcd_pkg::OP_UPDATE, egcd_pkg::C_ALWAYS, egcd_pkg::PC_TEST};
			egcd_pkg::PC_EMIT:
				word = '{egcd_pkg::OP_EMIT, egcd_pkg::C_OUT_FULL, egcd_pkg::PC_EMIT};
			egcd_pkg::PC_RETURN:
				word = '{egcd_pkg::OP_NOP, egcd_pkg::C_ALWAYS, egcd_pkg::PC_IDLE};
			default:
				word = '{egcd_pkg::OP_NOP, egcd_pkg::C_ALWAYS, egcd_pkg::PC_IDLE};
		endcase
	end

endmodule
`default_nettype wire

@@ rtl/egcd_sequencer.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// egcd_sequencer
// Step counter over the control store with conditional jumps; decodes the
// current micro-op into datapath strobes.
// ----------------------------------------------------------------------------
module egcd_sequencer (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 in_valid,
	input  wire logic                 out_full,
	input  wire egcd_pkg::dp_status_t status,
	output egcd_pkg::seq_ctrl_t       ctrl
);

	egcd_pkg::pc_t    pc_q;
	egcd_pkg::pc_t    pc_next;
	egcd_pkg::ucode_t word;
	logic             take_jump;

	egcd_ucode_rom u_rom (
		.addr (pc_q),
		.word (word)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= egcd_pkg::PC_IDLE;
		end else begin
			pc_q <= pc_next;
		end
	end

	always_comb begin
		unique case (word.cond)
			egcd_pkg::C_NEVER:     take_jump = 1'b0;
			egcd_pkg::C_ALWAYS:    take_jump = 1'b1;
			egcd_pkg::C_NO_INPUT:  take_jump = !in_valid;
			egcd_pkg::C_RCUR_ZERO: take_jump = status.rcur_zero;
			egcd_pkg::C_DIV_BUSY:  take_jump = !status.div_last;
			egcd_pkg::C_OUT_FULL:  take_jump = out_full;
			default:               take_jump = 1'b1;
		endcase
		pc_next = take_jump ? word.target : pc_q + 3'd1;
	end

	always_comb begin
		ctrl          = '0;
		ctrl.in_ready = (word.op == egcd_pkg::OP_ACCEPT);
		ctrl.load     = ctrl.in_ready && in_valid;
		ctrl.div_init = (word.op == egcd_pkg::OP_DIV_INIT);
		ctrl.div_step = (word.op == egcd_pkg::OP_DIV_STEP);
		ctrl.update   = (word.op == egcd_pkg::OP_UPDATE);
		ctrl.emit     = (word.op == egcd_pkg::OP_EMIT) && !out_full;
	end

endmodule
`default_nettype wire

@@ rtl/egcd_datapath.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// egcd_datapath
// Remainder and coefficient registers with a bit-serial restoring divider.
// Quotient bits come out msb first and are folded straight into q*s and q*t
// by shift-and-add, so no multiplier is needed.
// ----------------------------------------------------------------------------
module egcd_datapath #(
	parameter int WIDTH = 32
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire egcd_pkg::seq_ctrl_t ctrl,
	input  wire logic [WIDTH-1:0] first_operand,
	input  wire logic [WIDTH-1:0] second_operand,
	output egcd_pkg::dp_status_t  status,
	output logic      [WIDTH-1:0] coeff_x,
	output logic      [WIDTH-1:0] coeff_y,
	output logic      [WIDTH-1:0] divisor_d
);

	localparam int CW = $clog2(WIDTH + 1);

	logic [WIDTH-1:0] r_prev_q, r_cur_q;
	logic [WIDTH-1:0] s_prev_q, s_cur_q;
	logic [WIDTH-1:0] t_prev_q, t_cur_q;
	logic [WIDTH-1:0] rem_q, dvd_q, dsr_q;
	logic [WIDTH-1:0] acc_s_q, acc_t_q;
	logic [CW-1:0]    count_q;

	logic [WIDTH:0]   rem_sh;
	logic [WIDTH:0]   diff;
	logic             qbit;
	logic [WIDTH-1:0] rem_n;
	logic [WIDTH-1:0] acc_s_n, acc_t_n;
	logic             quot_neg;
	logic [WIDTH-1:0] r_next, s_next, t_next;
	logic [WIDTH-1:0] mag_prev, mag_cur;

	always_comb begin
		mag_prev = r_prev_q[WIDTH-1] ? ('0 - r_prev_q) : r_prev_q;
		mag_cur  = r_cur_q[WIDTH-1]  ? ('0 - r_cur_q)  : r_cur_q;

		// partial remainder is below the divisor, so the shifted value fits WIDTH bits
		rem_sh  = {rem_q, dvd_q[WIDTH-1]};
		diff    = rem_sh - {1'b0, dsr_q};
		qbit    = !diff[WIDTH];
		rem_n   = qbit ? diff[WIDTH-1:0] : rem_sh[WIDTH-1:0];
		acc_s_n = {acc_s_q[WIDTH-2:0], 1'b0} + (qbit ? s_cur_q : '0);
		acc_t_n = {acc_t_q[WIDTH-2:0], 1'b0} + (qbit ? t_cur_q : '0);

		// truncating division: remainder follows the dividend sign
		quot_neg = r_prev_q[WIDTH-1] ^ r_cur_q[WIDTH-1];
		r_next   = r_prev_q[WIDTH-1] ? ('0 - rem_q) : rem_q;
		s_next   = quot_neg ? (s_prev_q + acc_s_q) : (s_prev_q - acc_s_q);
		t_next   = quot_neg ? (t_prev_q + acc_t_q) : (t_prev_q - acc_t_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (ctrl.div_init) begin
			count_q <= CW'(WIDTH);
		end else if (ctrl.div_step) begin
			count_q <= count_q - CW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			r_prev_q <= first_operand;
			r_cur_q  <= second_operand;
			s_prev_q <= WIDTH'(1);
			s_cur_q  <= '0;
			t_prev_q <= '0;
			t_cur_q  <= WIDTH'(1);
		end else if (ctrl.update) begin
			r_prev_q <= r_cur_q;
			r_cur_q  <= r_next;
			s_prev_q <= s_cur_q;
			s_cur_q  <= s_next;
			t_prev_q <= t_cur_q;
			t_cur_q  <= t_next;
		end

		if (ctrl.div_init) begin
			rem_q   <= '0;
			dvd_q   <= mag_prev;
			dsr_q   <= mag_cur;
			acc_s_q <= '0;
			acc_t_q <= '0;
		end else if (ctrl.div_step) begin
			rem_q   <= rem_n;
			dvd_q   <= {dvd_q[WIDTH-2:0], 1'b0};
			acc_s_q <= acc_s_n;
			acc_t_q <= acc_t_n;
		end
	end

	assign status.rcur_zero = (r_cur_q == '0);
	assign status.div_last  = (count_q == CW'(1));
	assign coeff_x          = s_prev_q;
	assign coeff_y          = t_prev_q;
	assign divisor_d        = r_prev_q;

endmodule
`default_nettype wire

@@ rtl/extended_gcd_unit.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// extended_gcd_unit
// Extended euclid on signed operands a and b: returns x, y, d with
// a*x + b*y = d, using truncating division along the remainder chain.
// ----------------------------------------------------------------------------
// One pair is worked on at a time. The number of remainder steps is at most about
// 46 for 32-bit operands. Each remainder step is one pass of the bit-serial divider,
// one quotient bit per cycle, with the coefficient products accumulated in the same
// cycles. b equal to zero gives x=1, y=0, d=a without a divider pass. The result
// sits in an output register, so the next pair is taken while the previous result
// still waits on the master side.
module extended_gcd_unit #(
	parameter int WIDTH = 32
) (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 s_axis_tvalid,
	output logic                                      s_axis_tready,
	// first_operand, second_operand
	input  wire logic [((2*WIDTH+7)/8)*8-1:0]         s_axis_tdata,
	output logic                                      m_axis_tvalid,
	input  wire logic                                 m_axis_tready,
	// coeff_x, coeff_y, divisor_d
	output logic      [((3*WIDTH+7)/8)*8-1:0]         m_axis_tdata
);

	localparam int OUT_W = ((3*WIDTH+7)/8)*8;

	egcd_pkg::seq_ctrl_t  ctrl;
	egcd_pkg::dp_status_t status;
	logic [WIDTH-1:0]     coeff_x, coeff_y, divisor_d;
	logic [3*WIDTH-1:0]   result_q;
	logic                 out_valid_q;
	logic                 out_full;

	// output register frees up in the same cycle its beat is taken
	assign out_full = out_valid_q && !m_axis_tready;

	egcd_sequencer u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.out_full (out_full),
		.status   (status),
		.ctrl     (ctrl)
	);

	egcd_datapath #(
		.WIDTH (WIDTH)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.ctrl           (ctrl),
		.first_operand  (s_axis_tdata[WIDTH-1:0]),
		.second_operand (s_axis_tdata[2*WIDTH-1:WIDTH]),
		.status         (status),
		.coeff_x        (coeff_x),
		.coeff_y        (coeff_y),
		.divisor_d      (divisor_d)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (ctrl.emit) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.emit) begin
			result_q <= {divisor_d, coeff_y, coeff_x};
		end
	end

	assign s_axis_tready = ctrl.in_ready;
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = OUT_W'(result_q);

endmodule
`default_nettype wire

@@ rtl/egcd_checker.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// egcd_checker
// Port-level checks for the extended gcd unit, bound to the top level.
// ----------------------------------------------------------------------------
module egcd_checker #(
	parameter int WIDTH = 32
) (
	input wire logic                             clk,
	input wire logic                             arst_n,
	input wire logic                             s_axis_tvalid,
	input wire logic                             s_axis_tready,
	input wire logic [((2*WIDTH+7)/8)*8-1:0]     s_axis_tdata,
	input wire logic                             m_axis_tvalid,
	input wire logic                             m_axis_tready,
	input wire logic [((3*WIDTH+7)/8)*8-1:0]     m_axis_tdata
);

	// stalled result beat holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("result beat changed while stalled");

	// one pair in work at a time
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
		else $error("input taken again straight after a beat");

	// a new result only appears while a pair is in work
	a_result_from_work: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_axis_tvalid) |-> $past(!s_axis_tready))
		else $error("result appeared with no pair in work");

	// zero second operand returns x=1, y=0, d=a after the short path
	a_zero_b: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready && (s_axis_tdata[2*WIDTH-1:WIDTH] == '0)
		&& (!m_axis_tvalid || m_axis_tready)
		|-> ##3 m_axis_tvalid
		&& (m_axis_tdata[WIDTH-1:0] == WIDTH'(1))
		&& (m_axis_tdata[2*WIDTH-1:WIDTH] == '0)
		&& (m_axis_tdata[3*WIDTH-1:2*WIDTH] == $past(s_axis_tdata[WIDTH-1:0], 3)))
		else $error("wrong result for zero second operand");

endmodule

bind extended_gcd_unit egcd_checker #(.WIDTH(WIDTH)) u_chk (.*);
`default_nettype wire

@@ tb/tb_extended_gcd_unit.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// tb_extended_gcd_unit
// Self-checking bench for the extended gcd unit. A directed table of corner
// pairs is followed by random pairs (Fibonacci chains, shared factors, zeros,
// extremes and plain noise). Each result beat is checked field by field
// against a typed-in result or a bench-side Bezout solver, under four idling patterns.
// ----------------------------------------------------------------------------
module tb_extended_gcd_unit;

	localparam int W          = 32;
	localparam int CYCLE_CAP  = 3_000_000;
	localparam int TAIL_WAIT  = 40;
	localparam int REPORT_MAX = 10;

	localparam logic [W-1:0] POS_MAX = 32'h7fff_ffff;
	localparam logic [W-1:0] NEG_MIN = 32'h8000_0000;
	localparam logic [W-1:0] NEG_ONE = 32'hffff_ffff;
	localparam logic [W-1:0] FIB_46  = 32'd1836311903;
	localparam logic [W-1:0] FIB_45  = 32'd1134903170;

	typedef struct packed {
		logic [W-1:0] x;
		logic [W-1:0] y;
		logic [W-1:0] d;
	} bezout_t;

	typedef struct packed {
		logic [W-1:0] a;
		logic [W-1:0] b;
		bit           known;
		logic [W-1:0] x;
		logic [W-1:0] y;
		logic [W-1:0] d;
	} pair_row_t;

	localparam int ROWS = 25;

	// known rows carry the result typed in, the rest go through the solver
	localparam pair_row_t corner_pairs [0:ROWS-1] = '{
		'{NEG_MIN, NEG_ONE, 1'b1, 32'd0, 32'd1, NEG_ONE},
		'{32'd5, 32'd0, 1'b1, 32'd1, 32'd0, 32'd5},
		'{POS_MAX, 32'd0, 1'b1, 32'd1, 32'd0, POS_MAX},
		'{NEG_MIN, 32'd0, 1'b1, 32'd1, 32'd0, NEG_MIN},
		'{-32'sd5, 32'd0, 1'b1, 32'd1, 32'd0, -32'sd5},
		'{32'd0, 32'd0, 1'b1, 32'd1, 32'd0, 32'd0},
		'{32'd0, 32'd7, 1'b1, 32'd0, 32'd1, 32'd7},
		'{32'd0, NEG_MIN, 1'b1, 32'd0, 32'd1, NEG_MIN},
		'{32'd0, -32'sd7, 1'b1, 32'd0, 32'd1, -32'sd7},
		'{32'd1, 32'd1, 1'b0, 32'd0, 32'd0, 32'd0},
		'{POS_MAX, POS_MAX, 1'b0, 32'd0, 32'd0, 32'd0},
		'{POS_MAX, -POS_MAX, 1'b0, 32'd0, 32'd0, 32'd0},
		'{POS_MAX, 32'd1, 1'b0, 32'd0, 32'd0, 32'd0},
		'{32'd1, POS_MAX, 1'b0, 32'd0, 32'd0, 32'd0},
		'{NEG_MIN, NEG_MIN, 1'b0, 32'd0, 32'd0, 32'd0},
		'{NEG_MIN, 32'd1, 1'b0, 32'd0, 32'd0, 32'd0},
		'{NEG_MIN, POS_MAX, 1'b0, 32'd0, 32'd0, 32'd0},
		'{POS_MAX, NEG_MIN, 1'b0, 32'd0, 32'd0, 32'd0},
		'{FIB_46, FIB_45, 1'b0, 32'd0, 32'd0, 32'd0},
		'{-FIB_46, FIB_45, 1'b0, 32'd0, 32'd0, 32'd0},
		'{32'd240, 32'd46, 1'b0, 32'd0, 32'd0, 32'd0},
		'{-32'sd240, 32'd46, 1'b0, 32'd0, 32'd0, 32'd0},
		'{32'd240, -32'sd46, 1'b0, 32'd0, 32'd0, 32'd0},
		'{-32'sd240, -32'sd46, 1'b0, 32'd0, 32'd0, 32'd0},
		'{NEG_ONE, NEG_ONE, 1'b0, 32'd0, 32'd0, 32'd0}
	};

	logic           clk = 1'b0;
	logic           arst_n = 1'b0;
	logic           s_axis_tvalid = 1'b0;
	logic           s_axis_tready;
	// first_operand, second_operand
	logic [2*W-1:0] s_axis_tdata = '0;
	logic           m_axis_tvalid;
	logic           m_axis_tready = 1'b0;
	// coeff_x, coeff_y, divisor_d
	logic [3*W-1:0] m_axis_tdata;

	bezout_t pending_bezout [$];
	int      send_idle_pct = 0;
	int      recv_stall_pct = 0;
	int      recv_hold = 0;
	int      pairs_sent = 0;
	int      results_seen = 0;
	int      mismatches = 0;
	int      longest_chain = 0;
	int      cycle_count = 0;

	extended_gcd_unit #(.WIDTH(W)) uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	always #5 clk = ~clk;

	// truncating remainder chain on sign-extended 64-bit values, wrapping
	function automatic bezout_t bezout_solve(input logic [W-1:0] a, input logic [W-1:0] b,
			output int steps);
		logic [63:0] r_prev, r_cur, s_prev, s_cur, t_prev, t_cur;
		logic [63:0] quot, mag_n, mag_d, r_next, s_next, t_next;
		bezout_t res;
		r_prev = {{(64-W){a[W-1]}}, a};
		r_cur  = {{(64-W){b[W-1]}}, b};
		s_prev = 64'd1;
		s_cur  = 64'd0;
		t_prev = 64'd0;
		t_cur  = 64'd1;
		steps  = 0;
		while (r_cur != 64'd0 && steps < 2*W+4) begin
			mag_n = r_prev[63] ? -r_prev : r_prev;
			mag_d = r_cur[63] ? -r_cur : r_cur;
			quot  = mag_n / mag_d;
			if (r_prev[63] != r_cur[63]) begin
				quot = -quot;
			end
			r_next = r_prev - quot * r_cur;
			s_next = s_prev - quot * s_cur;
			t_next = t_prev - quot * t_cur;
			r_prev = r_cur;
			r_cur  = r_next;
			s_prev = s_cur;
			s_cur  = s_next;
			t_prev = t_cur;
			t_cur  = t_next;
			steps++;
		end
		res.x = s_prev[W-1:0];
		res.y = t_prev[W-1:0];
		res.d = r_prev[W-1:0];
		return res;
	endfunction

	task automatic draw_pair(output logic [W-1:0] a, output logic [W-1:0] b);
		int unsigned  kind;
		int           g;
		int           idx;
		logic [W-1:0] f_lo, f_hi, nxt, tmp;
		kind = $urandom_range(0, 99);
		if (kind < 45) begin
			a = $urandom;
			b = $urandom;
		end else if (kind < 60) begin
			a = $urandom_range(0, 400) - 200;
			b = $urandom_range(0, 400) - 200;
		end else if (kind < 75) begin
			// shared factor, so the gcd is not just one
			g = $urandom_range(1, 60000);
			a = g * ($urandom_range(0, 60000) - 30000);
			b = g * ($urandom_range(0, 60000) - 30000);
		end else if (kind < 85) begin
			// consecutive Fibonacci numbers give the longest chains
			idx  = $urandom_range(10, 46);
			f_lo = 32'd1;
			f_hi = 32'd1;
			repeat (idx - 2) begin
				nxt  = f_lo + f_hi;
				f_lo = f_hi;
				f_hi = nxt;
			end
			a = $urandom_range(0, 1) ? -f_hi : f_hi;
			b = $urandom_range(0, 1) ? -f_lo : f_lo;
			if ($urandom_range(0, 3) == 0) begin
				tmp = a;
				a   = b;
				b   = tmp;
			end
		end else if (kind < 92) begin
			a = $urandom;
			b = $urandom;
			if ($urandom_range(0, 1)) begin
				a = '0;
			end else begin
				b = '0;
			end
		end else begin
			case ($urandom_range(0, 3))
				0: a = POS_MAX;
				1: a = NEG_MIN;
				2: a = NEG_ONE;
				default: a = $urandom;
			endcase
			case ($urandom_range(0, 3))
				0: b = POS_MAX;
				1: b = NEG_MIN;
				2: b = 32'd1;
				default: b = $urandom;
			endcase
		end
	endtask

	task automatic offer_pair(input logic [W-1:0] a, input logic [W-1:0] b, input bit known,
			input bezout_t typed);
		int      gap;
		int      steps;
		bezout_t want;
		gap = 0;
		while (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct) begin
			gap++;
		end
		if (send_idle_pct != 0 && $urandom_range(0, 19) == 0) begin
			gap += $urandom_range(20, 300);
		end
		repeat (gap) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {b, a};
		do @(posedge clk); while (!s_axis_tready);
		want = bezout_solve(a, b, steps);
		if (known) begin
			want = typed;
		end
		if (steps > longest_chain) begin
			longest_chain = steps;
		end
		pending_bezout.insert(pending_bezout.size(), want);
		pairs_sent++;
	endtask

	task automatic wait_drained();
		while (pending_bezout.size() != 0) begin
			@(posedge clk);
		end
	endtask

	// result side: ready pattern and checking
	always @(posedge clk) begin
		bezout_t want;
		bezout_t got;
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				results_seen++;
				got.x = m_axis_tdata[W-1:0];
				got.y = m_axis_tdata[2*W-1:W];
				got.d = m_axis_tdata[3*W-1:2*W];
				if (pending_bezout.size() == 0) begin
					mismatches++;
					if (mismatches <= REPORT_MAX) begin
						$display("unexpected result beat x=%0d y=%0d d=%0d",
							$signed(got.x), $signed(got.y), $signed(got.d));
					end
				end else begin
					want = pending_bezout.pop_front();
					if (got.x !== want.x || got.y !== want.y || got.d !== want.d) begin
						mismatches++;
						if (mismatches <= REPORT_MAX) begin
							$display("result %0d: expected x=%0d y=%0d d=%0d, got x=%0d y=%0d d=%0d",
								results_seen, $signed(want.x), $signed(want.y),
								$signed(want.d), $signed(got.x), $signed(got.y),
								$signed(got.d));
						end
					end
				end
			end
			if (recv_hold > 0) begin
				recv_hold--;
				m_axis_tready <= 1'b0;
			end else if (recv_stall_pct != 0 && $urandom_range(0, 99) < recv_stall_pct) begin
				m_axis_tready <= 1'b0;
				if ($urandom_range(0, 29) == 0) begin
					recv_hold = $urandom_range(20, 300);
				end
			end else begin
				m_axis_tready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_CAP) begin
			$display("Some tests failed");
			$finish;
		end
	end

	initial begin
		logic [W-1:0] a, b;
		bezout_t      typed;
		int           phase;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < ROWS; i++) begin
			typed.x = corner_pairs[i].x;
			typed.y = corner_pairs[i].y;
			typed.d = corner_pairs[i].d;
			offer_pair(corner_pairs[i].a, corner_pairs[i].b, corner_pairs[i].known, typed);
		end

		// no idling, sender idle, receiver stalling, both
		for (phase = 0; phase < 4; phase++) begin
			case (phase)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 55; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 55; end
				default: begin send_idle_pct = 21; recv_stall_pct = 21; end
			endcase
			repeat (phase == 0 ? 75 : 90) begin
				draw_pair(a, b);
				offer_pair(a, b, 1'b0, typed);
			end
			// hold off until every beat in flight has come back
			s_axis_tvalid <= 1'b0;
			wait_drained();
			@(posedge clk);
		end

		wait_drained();
		repeat (TAIL_WAIT) @(posedge clk);
		$display("%0d operand pairs (%0d from the corner table), %0d results checked",
			pairs_sent, ROWS, results_seen);
		$display("longest remainder chain %0d steps, four idling patterns", longest_chain);
		if (mismatches == 0 && pending_bezout.size() == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule
`default_nettype wire
